@@ rtl/core/rep_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rep_pkg
// Shared constants, register codes and types of the ratio-error PD steering
// controller.
// ----------------------------------------------------------------------------
package rep_pkg;

  localparam int ADC_BITS_DEF    = 12;
  localparam int HISTORY_LAG_DEF = 3;
  localparam int QUEUE_DEPTH     = 2;

  localparam int GAIN_W  = 16;
  localparam int ERR_W   = 16;
  localparam int DRIVE_W = 16;

  localparam int FRAC_IN      = 16;
  localparam int RATIO_SHIFT  = 6;
  localparam int ROUND_SHIFT  = 16;
  localparam int ROUND_HALF   = 1 << (ROUND_SHIFT - 1);
  localparam int ONE_Q14      = 16384;
  localparam int SLOPE_FACTOR = 5;
  localparam int DRIVE_MAX    = 32767;
  localparam int DRIVE_MIN    = -32768;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd0;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd0;
  localparam logic [GAIN_W-1:0] RATIO_GAIN_RST = 16'd256;

  typedef enum logic [1:0] {
    REG_PROP  = 2'd0,
    REG_DERIV = 2'd1,
    REG_RATIO = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [GAIN_W-1:0] ratio_gain;
  } gains_t;

endpackage
`default_nettype wire

@@ rtl/core/rep_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rep_if
// Valid/ready channels of the steering controller: coil samples in,
// drive and error values out.
// ----------------------------------------------------------------------------
interface rep_in_if import rep_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] left_coil;
  logic [ADC_BITS-1:0] right_coil;

  modport source (output valid, left_coil, right_coil, input ready);
  modport sink   (input valid, left_coil, right_coil, output ready);
endinterface

interface rep_out_if import rep_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive_out;
  logic signed [ERR_W-1:0]   track_error;
  logic signed [ERR_W-1:0]   error_slope;

  modport source (output valid, drive_out, track_error, error_slope, input ready);
  modport sink   (input valid, drive_out, track_error, error_slope, output ready);
endinterface
`default_nettype wire

@@ rtl/core/rep_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rep_front
// Accepts coil samples and takes the square roots of both in parallel,
// two radicand bits per cycle, then offers the root pair to the queue.
// ----------------------------------------------------------------------------
module rep_front import rep_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  rep_in_if.sink                                  in_bus,
  output logic                                    res_valid,
  input  wire logic                               res_ready,
  output logic [2*((ADC_BITS + FRAC_IN + 1) / 2)-1:0] res_roots
);

  localparam int SQ_W  = (ADC_BITS + FRAC_IN + 1) / 2;
  localparam int X_W   = 2 * SQ_W;
  localparam int REM_W = SQ_W + 2;
  localparam int CNT_W = $clog2(SQ_W + 1);

  typedef struct packed {
    logic [X_W-1:0]   x;
    logic [REM_W-1:0] rem;
    logic [SQ_W-1:0]  root;
  } sq_t;

  function automatic sq_t sq_step(sq_t s);
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    sq_t              o;
    rem_sh = {s.rem[SQ_W-1:0], s.x[X_W-1 -: 2]};
    trial  = {s.root, 2'b01};
    o.x    = {s.x[X_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      o.rem  = rem_sh - trial;
      o.root = {s.root[SQ_W-2:0], 1'b1};
    end else begin
      o.rem  = rem_sh;
      o.root = {s.root[SQ_W-2:0], 1'b0};
    end
    return o;
  endfunction

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  sq_t              sl_r, sl_nxt;
  sq_t              sr_r, sr_nxt;
  logic             res_v_r, res_v_nxt;
  logic [X_W-1:0]   res_r, res_nxt;

  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    sl_nxt    = sl_r;
    sr_nxt    = sr_r;
    res_v_nxt = res_v_r;
    res_nxt   = res_r;
    if (res_v_r && res_ready) begin
      res_v_nxt = 1'b0;
    end
    if (!busy_r) begin
      if (in_bus.valid) begin
        busy_nxt    = 1'b1;
        cnt_nxt     = CNT_W'(SQ_W);
        sl_nxt.x    = X_W'({in_bus.left_coil, {FRAC_IN{1'b0}}});
        sl_nxt.rem  = '0;
        sl_nxt.root = '0;
        sr_nxt.x    = X_W'({in_bus.right_coil, {FRAC_IN{1'b0}}});
        sr_nxt.rem  = '0;
        sr_nxt.root = '0;
      end
    end else if (cnt_r != '0) begin
      sl_nxt  = sq_step(sl_r);
      sr_nxt  = sq_step(sr_r);
      cnt_nxt = cnt_r - 1'b1;
    end else if (!res_v_r || res_ready) begin
      res_v_nxt = 1'b1;
      res_nxt   = {sl_r.root, sr_r.root};
      busy_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      cnt_r   <= '0;
      res_v_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      cnt_r   <= cnt_nxt;
      res_v_r <= res_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sl_r  <= sl_nxt;
    sr_r  <= sr_nxt;
    res_r <= res_nxt;
  end

  assign in_bus.ready = !busy_r;
  assign res_valid    = res_v_r;
  assign res_roots    = res_r;

endmodule
`default_nettype wire

@@ rtl/core/rep_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rep_queue
// Short first-in first-out queue of root pairs between the front and the
// back.
// ----------------------------------------------------------------------------
module rep_queue import rep_pkg::*; #(
  parameter int WIDTH = 28,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/rep_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rep_back
// Forms the difference-over-sum error with a restoring divider, keeps the
// error history, and computes the derivative and the saturated drive.
// ----------------------------------------------------------------------------
module rep_back import rep_pkg::*; #(
  parameter int ADC_BITS    = ADC_BITS_DEF,
  parameter int HISTORY_LAG = HISTORY_LAG_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire gains_t                                     gains,
  input  wire logic                                       q_valid,
  output logic                                            q_ready,
  input  wire logic [2*((ADC_BITS + FRAC_IN + 1) / 2)-1:0] q_roots,
  rep_out_if.source                                       out_bus
);

  localparam int SQ_W   = (ADC_BITS + FRAC_IN + 1) / 2;
  localparam int SUM_W  = SQ_W + 1;
  localparam int PROD_W = GAIN_W + SQ_W;
  localparam int NUM_W  = PROD_W + RATIO_SHIFT;
  localparam int DCNT_W = $clog2(NUM_W + 1);
  localparam int DIFF_W = ERR_W + 1;
  localparam int SLP_W  = DIFF_W + 3;
  localparam int PRD_W  = GAIN_W + ERR_W + 1;
  localparam int ACC_W  = PRD_W + 1;

  typedef enum logic [7:0] {
    B_IDLE  = 8'b0000_0001,
    B_MULG  = 8'b0000_0010,
    B_DIV   = 8'b0000_0100,
    B_ERR   = 8'b0000_1000,
    B_SLOPE = 8'b0001_0000,
    B_MULP  = 8'b0010_0000,
    B_MULD  = 8'b0100_0000,
    B_FIN   = 8'b1000_0000
  } bstate_t;

  bstate_t                   state_r, state_nxt;
  logic [SQ_W-1:0]           sl_r, sl_nxt;
  logic [SQ_W-1:0]           sr_r, sr_nxt;
  logic [SUM_W-1:0]          sum_r, sum_nxt;
  logic [NUM_W-1:0]          num_r, num_nxt;
  logic [SUM_W-1:0]          rem_r, rem_nxt;
  logic [NUM_W-1:0]          quo_r, quo_nxt;
  logic                      pos_r, pos_nxt;
  logic [DCNT_W-1:0]         dcnt_r, dcnt_nxt;
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic signed [ERR_W-1:0]   slope_r, slope_nxt;
  logic signed [ERR_W-1:0]   hist_r [HISTORY_LAG];
  logic                      hist_shift;
  logic signed [PRD_W-1:0]   p_r, p_nxt;
  logic signed [PRD_W-1:0]   d_r, d_nxt;
  logic                      out_v_r, out_v_nxt;
  logic signed [DRIVE_W-1:0] drive_r, drive_nxt;
  logic signed [ERR_W-1:0]   oerr_r, oerr_nxt;
  logic signed [ERR_W-1:0]   oslope_r, oslope_nxt;

  logic [SQ_W-1:0]           mag;
  logic [PROD_W-1:0]         prod;
  logic [SUM_W:0]            rem_sh;
  logic [ERR_W-1:0]          qsat;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [SLP_W-1:0]   slope_full;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_sh;

  always_comb begin
    state_nxt  = state_r;
    sl_nxt     = sl_r;
    sr_nxt     = sr_r;
    sum_nxt    = sum_r;
    num_nxt    = num_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    pos_nxt    = pos_r;
    dcnt_nxt   = dcnt_r;
    err_nxt    = err_r;
    slope_nxt  = slope_r;
    p_nxt      = p_r;
    d_nxt      = d_r;
    out_v_nxt  = out_v_r;
    drive_nxt  = drive_r;
    oerr_nxt   = oerr_r;
    oslope_nxt = oslope_r;
    hist_shift = 1'b0;
    q_ready    = 1'b0;

    mag        = (sl_r >= sr_r) ? sl_r - sr_r : sr_r - sl_r;
    prod       = PROD_W'(gains.ratio_gain) * PROD_W'(mag);
    rem_sh     = {rem_r, num_r[NUM_W-1]};
    qsat       = (quo_r > NUM_W'(ONE_Q14)) ? ERR_W'(ONE_Q14) : quo_r[ERR_W-1:0];
    diff       = DIFF_W'(err_r) - DIFF_W'(hist_r[HISTORY_LAG-1]);
    slope_full = SLP_W'(diff) * SLP_W'(SLOPE_FACTOR);
    acc        = ACC_W'(p_r) + ACC_W'(d_r) + ACC_W'(ROUND_HALF);
    acc_sh     = acc >>> ROUND_SHIFT;

    if (out_v_r && out_bus.ready) begin
      out_v_nxt = 1'b0;
    end

    unique case (state_r)
      B_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          sl_nxt    = q_roots[2*SQ_W-1:SQ_W];
          sr_nxt    = q_roots[SQ_W-1:0];
          state_nxt = B_MULG;
        end
      end
      B_MULG: begin
        sum_nxt   = SUM_W'(sl_r) + SUM_W'(sr_r);
        pos_nxt   = (sl_r >= sr_r);
        num_nxt   = {prod, {RATIO_SHIFT{1'b0}}};
        rem_nxt   = '0;
        quo_nxt   = '0;
        dcnt_nxt  = DCNT_W'(NUM_W);
        state_nxt = B_DIV;
      end
      B_DIV: begin
        if (dcnt_r != '0) begin
          num_nxt  = {num_r[NUM_W-2:0], 1'b0};
          dcnt_nxt = dcnt_r - 1'b1;
          if (rem_sh >= {1'b0, sum_r}) begin
            rem_nxt = SUM_W'(rem_sh - {1'b0, sum_r});
            quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
          end else begin
            rem_nxt = rem_sh[SUM_W-1:0];
            quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
          end
        end else begin
          state_nxt = B_ERR;
        end
      end
      B_ERR: begin
        if (sum_r == '0) begin
          err_nxt = '0;
        end else if (pos_r) begin
          err_nxt = $signed(qsat);
        end else begin
          err_nxt = -$signed(qsat);
        end
        state_nxt = B_SLOPE;
      end
      B_SLOPE: begin
        if (slope_full > SLP_W'(ONE_Q14)) begin
          slope_nxt = ERR_W'(ONE_Q14);
        end else if (slope_full < SLP_W'(-ONE_Q14)) begin
          slope_nxt = ERR_W'(-ONE_Q14);
        end else begin
          slope_nxt = slope_full[ERR_W-1:0];
        end
        hist_shift = 1'b1;
        state_nxt  = B_MULP;
      end
      B_MULP: begin
        p_nxt     = PRD_W'($signed({1'b0, gains.prop_gain})) * PRD_W'(err_r);
        state_nxt = B_MULD;
      end
      B_MULD: begin
        d_nxt     = PRD_W'($signed({1'b0, gains.deriv_gain})) * PRD_W'(slope_r);
        state_nxt = B_FIN;
      end
      B_FIN: begin
        if (!out_v_r || out_bus.ready) begin
          if (acc_sh > ACC_W'(DRIVE_MAX)) begin
            drive_nxt = DRIVE_W'(DRIVE_MAX);
          end else if (acc_sh < ACC_W'(DRIVE_MIN)) begin
            drive_nxt = DRIVE_W'(DRIVE_MIN);
          end else begin
            drive_nxt = acc_sh[DRIVE_W-1:0];
          end
          oerr_nxt   = err_r;
          oslope_nxt = slope_r;
          out_v_nxt  = 1'b1;
          state_nxt  = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      dcnt_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dcnt_r  <= dcnt_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_LAG; i++) begin
        hist_r[i] <= '0;
      end
    end else if (hist_shift) begin
      for (int i = HISTORY_LAG - 1; i > 0; i--) begin
        hist_r[i] <= hist_r[i-1];
      end
      hist_r[0] <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    sl_r     <= sl_nxt;
    sr_r     <= sr_nxt;
    sum_r    <= sum_nxt;
    num_r    <= num_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    pos_r    <= pos_nxt;
    err_r    <= err_nxt;
    slope_r  <= slope_nxt;
    p_r      <= p_nxt;
    d_r      <= d_nxt;
    drive_r  <= drive_nxt;
    oerr_r   <= oerr_nxt;
    oslope_r <= oslope_nxt;
  end

  assign out_bus.valid       = out_v_r;
  assign out_bus.drive_out   = drive_r;
  assign out_bus.track_error = oerr_r;
  assign out_bus.error_slope = oslope_r;

endmodule
`default_nettype wire

@@ rtl/core/ratio_error_pd_steering_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ratio_error_pd_steering_top
// Difference-over-sum steering controller with PD drive output.
//
//   Channel  Direction  Beat contents
//   in_bus   sink       left_coil, right_coil
//   out_bus  source     drive_out, track_error, error_slope
//   cfg_*    APB slave  prop_gain @0x0, deriv_gain @0x4, ratio_gain @0x8
//
// The front's pace per beat is set by the two parallel square-root units
// retiring one result bit a cycle. The back's pace per beat is set by the
// restoring divider at one quotient bit a cycle; the back sets the
// sustained rate. A two-entry queue lets the front run ahead of the back.
// Reset is synchronous; the error history clears to zero at once.
// Output stalls back up through the back, the queue and the front in turn.
// ----------------------------------------------------------------------------
module ratio_error_pd_steering_top import rep_pkg::*; #(
  parameter int ADC_BITS    = ADC_BITS_DEF,
  parameter int HISTORY_LAG = HISTORY_LAG_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  rep_in_if.sink                     in_bus,
  rep_out_if.source                  out_bus,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  localparam int SQ_W = (ADC_BITS + FRAC_IN + 1) / 2;

  gains_t            gains_r;
  reg_idx_t          idx;
  logic              wr_en;
  logic              front_valid;
  logic              front_ready;
  logic [2*SQ_W-1:0] front_roots;
  logic              q_valid;
  logic              q_ready;
  logic [2*SQ_W-1:0] q_roots;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.prop_gain  <= PROP_GAIN_RST;
      gains_r.deriv_gain <= DERIV_GAIN_RST;
      gains_r.ratio_gain <= RATIO_GAIN_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_PROP:  gains_r.prop_gain  <= cfg_pwdata[GAIN_W-1:0];
        REG_DERIV: gains_r.deriv_gain <= cfg_pwdata[GAIN_W-1:0];
        REG_RATIO: gains_r.ratio_gain <= cfg_pwdata[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PROP:  cfg_prdata = CFG_DATA_W'(gains_r.prop_gain);
      REG_DERIV: cfg_prdata = CFG_DATA_W'(gains_r.deriv_gain);
      REG_RATIO: cfg_prdata = CFG_DATA_W'(gains_r.ratio_gain);
      default:   cfg_prdata = '0;
    endcase
  end

  rep_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .res_valid (front_valid),
    .res_ready (front_ready),
    .res_roots (front_roots)
  );

  rep_queue #(
    .WIDTH (2 * SQ_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_roots),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_roots)
  );

  rep_back #(
    .ADC_BITS    (ADC_BITS),
    .HISTORY_LAG (HISTORY_LAG)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .gains   (gains_r),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_roots (q_roots),
    .out_bus (out_bus)
  );

endmodule
`default_nettype wire
